### rtl/core/mfbt_pkg.sv
// ----------------------------------------------------------------------------
// mfbt_pkg
// Shared constants, codes and types of the message queue with byte total.
// ----------------------------------------------------------------------------
package mfbt_pkg;

    localparam int QUEUE_DEPTH   = 4;
    localparam int MAX_MSG_BYTES = 8;
    localparam int MSG_SLOTS     = 8;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 4;
    localparam int TOTAL_W       = 6;
    localparam int ACTION_W      = 2;
    localparam int IDX_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W         = IDX_W + 1;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_APPEND = 2'd0;
    localparam action_t ACT_REMOVE = 2'd1;
    localparam action_t ACT_FLUSH  = 2'd2;

    typedef logic [MSG_SLOTS-1:0][BYTE_W-1:0] msg_t;

    typedef struct packed {
        logic step;
    } dp_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } ctrl_state_t;

endpackage

### rtl/core/mfbt_ctrl.sv
// ----------------------------------------------------------------------------
// mfbt_ctrl
// Handshake controller: tracks whether a result beat is held and issues
// the step command to the datapath.
// ----------------------------------------------------------------------------
module mfbt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mfbt_pkg::dp_cmd_t cmd
);

    mfbt_pkg::ctrl_state_t state_reg;
    mfbt_pkg::ctrl_state_t state_next;

    assign in_ready  = (state_reg == mfbt_pkg::ST_IDLE) || out_ready;
    assign out_valid = (state_reg == mfbt_pkg::ST_HOLD);
    assign cmd.step  = in_valid && in_ready;

    always_comb
    begin
        case (state_reg)
            mfbt_pkg::ST_IDLE:
            begin
                state_next = cmd.step ? mfbt_pkg::ST_HOLD : mfbt_pkg::ST_IDLE;
            end
            mfbt_pkg::ST_HOLD:
            begin
                if (cmd.step)
                begin
                    state_next = mfbt_pkg::ST_HOLD;
                end
                else if (out_ready)
                begin
                    state_next = mfbt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mfbt_pkg::ST_HOLD;
                end
            end
            default:
            begin
                state_next = mfbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/mfbt_dpath.sv
// ----------------------------------------------------------------------------
// mfbt_dpath
// Datapath: circular message store, head and count pointers, running byte
// total and the registered result beat.
// ----------------------------------------------------------------------------
module mfbt_dpath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mfbt_pkg::dp_cmd_t                    cmd,
    input  mfbt_pkg::action_t                    action,
    input  logic [mfbt_pkg::LEN_W-1:0]           msg_length,
    input  mfbt_pkg::msg_t                       msg,
    output logic                                 append_ok,
    output logic                                 head_valid,
    output logic [mfbt_pkg::LEN_W-1:0]           head_length,
    output mfbt_pkg::msg_t                       head_msg,
    output logic [mfbt_pkg::TOTAL_W-1:0]         total_bytes
);

    mfbt_pkg::msg_t                     msg_mem [mfbt_pkg::QUEUE_DEPTH];
    logic [mfbt_pkg::LEN_W-1:0]         len_mem [mfbt_pkg::QUEUE_DEPTH];

    logic [mfbt_pkg::IDX_W-1:0]         head_reg;
    logic [mfbt_pkg::IDX_W-1:0]         head_next;
    logic [mfbt_pkg::CNT_W-1:0]         count_reg;
    logic [mfbt_pkg::CNT_W-1:0]         count_next;
    logic [mfbt_pkg::TOTAL_W-1:0]       total_reg;
    logic [mfbt_pkg::TOTAL_W-1:0]       total_next;

    logic                               append_ok_reg;
    logic                               head_valid_reg;
    logic [mfbt_pkg::LEN_W-1:0]         head_length_reg;
    mfbt_pkg::msg_t                     head_msg_reg;
    logic [mfbt_pkg::TOTAL_W-1:0]       total_bytes_reg;

    logic                               have;
    logic                               full;
    logic                               do_append;
    logic                               do_remove;
    logic                               do_flush;
    logic [mfbt_pkg::LEN_W-1:0]         len_sat;
    mfbt_pkg::msg_t                     msg_masked;
    logic [mfbt_pkg::SUM_W-1:0]         tail_sum;
    logic [mfbt_pkg::IDX_W-1:0]         tail_idx;
    logic [mfbt_pkg::SUM_W-1:0]         inc_sum;
    logic [mfbt_pkg::IDX_W-1:0]         head_inc;
    logic [mfbt_pkg::LEN_W-1:0]         cur_len;
    mfbt_pkg::msg_t                     cur_msg;

    assign have = (count_reg != '0);
    assign full = (count_reg == mfbt_pkg::CNT_W'(mfbt_pkg::QUEUE_DEPTH));

    assign do_append = cmd.step && (action == mfbt_pkg::ACT_APPEND) && !full;
    assign do_remove = cmd.step && (action == mfbt_pkg::ACT_REMOVE) && have;
    assign do_flush  = cmd.step && (action == mfbt_pkg::ACT_FLUSH);

    assign len_sat = (msg_length > mfbt_pkg::LEN_W'(mfbt_pkg::MAX_MSG_BYTES))
                   ? mfbt_pkg::LEN_W'(mfbt_pkg::MAX_MSG_BYTES) : msg_length;

    // bytes past the length are stored as zero
    always_comb
    begin
        for (int k = 0; k < mfbt_pkg::MSG_SLOTS; k++)
        begin
            msg_masked[k] = (mfbt_pkg::LEN_W'(k) < len_sat) ? msg[k] : '0;
        end
    end

    // wrap by one compare and subtract
    assign tail_sum = mfbt_pkg::SUM_W'(head_reg) + mfbt_pkg::SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= mfbt_pkg::SUM_W'(mfbt_pkg::QUEUE_DEPTH))
                    ? mfbt_pkg::IDX_W'(tail_sum - mfbt_pkg::SUM_W'(mfbt_pkg::QUEUE_DEPTH))
                    : mfbt_pkg::IDX_W'(tail_sum);

    assign inc_sum  = mfbt_pkg::SUM_W'(head_reg) + mfbt_pkg::SUM_W'(1);
    assign head_inc = (inc_sum >= mfbt_pkg::SUM_W'(mfbt_pkg::QUEUE_DEPTH))
                    ? '0 : mfbt_pkg::IDX_W'(inc_sum);

    assign cur_len = have ? len_mem[head_reg] : '0;
    assign cur_msg = have ? msg_mem[head_reg] : '0;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        total_next = total_reg;
        if (do_append)
        begin
            count_next = count_reg + mfbt_pkg::CNT_W'(1);
            total_next = total_reg + mfbt_pkg::TOTAL_W'(len_sat);
        end
        else if (do_remove)
        begin
            head_next  = head_inc;
            count_next = count_reg - mfbt_pkg::CNT_W'(1);
            total_next = total_reg - mfbt_pkg::TOTAL_W'(cur_len);
        end
        else if (do_flush)
        begin
            head_next  = '0;
            count_next = '0;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            msg_mem[tail_idx] <= msg_masked;
            len_mem[tail_idx] <= len_sat;
        end
    end

    // result beat, head as it stood before the step
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            append_ok_reg   <= do_append;
            head_valid_reg  <= have;
            head_length_reg <= cur_len;
            head_msg_reg    <= cur_msg;
            total_bytes_reg <= total_next;
        end
    end

    assign append_ok   = append_ok_reg;
    assign head_valid  = head_valid_reg;
    assign head_length = head_length_reg;
    assign head_msg    = head_msg_reg;
    assign total_bytes = total_bytes_reg;

endmodule

### rtl/core/message_fifo_with_byte_total.sv
// ----------------------------------------------------------------------------
// message_fifo_with_byte_total
// A result beat is registered when its input beat is accepted and appears in
// the cycle after. Throughput: one item per cycle while no result beat is held
// or out_ready is high; a held result beat is replaced as it is taken.
// Reset: asynchronous, empties the queue, clears head, count and total.
// Message store contents are not cleared.
// ----------------------------------------------------------------------------
module message_fifo_with_byte_total
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mfbt_pkg::ACTION_W-1:0]        action,
    input  logic [mfbt_pkg::LEN_W-1:0]           msg_length,
    input  logic [mfbt_pkg::BYTE_W-1:0]          in_byte0,
    input  logic [mfbt_pkg::BYTE_W-1:0]          in_byte1,
    input  logic [mfbt_pkg::BYTE_W-1:0]          in_byte2,
    input  logic [mfbt_pkg::BYTE_W-1:0]          in_byte3,
    input  logic [mfbt_pkg::BYTE_W-1:0]          in_byte4,
    input  logic [mfbt_pkg::BYTE_W-1:0]          in_byte5,
    input  logic [mfbt_pkg::BYTE_W-1:0]          in_byte6,
    input  logic [mfbt_pkg::BYTE_W-1:0]          in_byte7,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 append_ok,
    output logic                                 head_valid,
    output logic [mfbt_pkg::LEN_W-1:0]           head_length,
    output logic [mfbt_pkg::BYTE_W-1:0]          out_byte0,
    output logic [mfbt_pkg::BYTE_W-1:0]          out_byte1,
    output logic [mfbt_pkg::BYTE_W-1:0]          out_byte2,
    output logic [mfbt_pkg::BYTE_W-1:0]          out_byte3,
    output logic [mfbt_pkg::BYTE_W-1:0]          out_byte4,
    output logic [mfbt_pkg::BYTE_W-1:0]          out_byte5,
    output logic [mfbt_pkg::BYTE_W-1:0]          out_byte6,
    output logic [mfbt_pkg::BYTE_W-1:0]          out_byte7,
    output logic [mfbt_pkg::TOTAL_W-1:0]         total_bytes
);

    mfbt_pkg::dp_cmd_t cmd;
    mfbt_pkg::msg_t    in_msg;
    mfbt_pkg::msg_t    out_msg;

    assign in_msg = {in_byte7, in_byte6, in_byte5, in_byte4,
                     in_byte3, in_byte2, in_byte1, in_byte0};

    assign out_byte0 = out_msg[0];
    assign out_byte1 = out_msg[1];
    assign out_byte2 = out_msg[2];
    assign out_byte3 = out_msg[3];
    assign out_byte4 = out_msg[4];
    assign out_byte5 = out_msg[5];
    assign out_byte6 = out_msg[6];
    assign out_byte7 = out_msg[7];

    mfbt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mfbt_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .msg_length  (msg_length),
        .msg         (in_msg),
        .append_ok   (append_ok),
        .head_valid  (head_valid),
        .head_length (head_length),
        .head_msg    (out_msg),
        .total_bytes (total_bytes)
    );

endmodule
